@@ rtl/des_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package des_pkg;

   localparam int RoundCount = 16;
   localparam int HalfKeyBits = 28;
   localparam int SubkeyBits = 48;
   localparam int HalfBlockBits = 32;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   typedef logic [SubkeyBits-1:0] subkey_type;
   typedef subkey_type [RoundCount-1:0] subkey_set_type;

   typedef struct packed {
      logic        func;
      logic [63:0] block;
   } req_item_type;

   localparam byte IP_TAB [64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

   localparam byte FP_TAB [64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

   localparam byte E_TAB [48] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
      28,29,30,31,32,1};

   localparam byte P_TAB [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

   localparam byte PC1_TAB [56] = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,
      10,2,59,51,43,35,27,19,11,3,60,52,44,36,
      63,55,47,39,31,23,15,7,62,54,46,38,30,22,
      14,6,61,53,45,37,29,21,13,5,28,20,12,4};

   localparam byte PC2_TAB [48] = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};

   localparam byte SHIFT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

   localparam byte SBOX [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
        0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
        15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
        3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
        13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
        13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
        1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
        13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
        3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
        14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
        11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
        10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
        4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
        13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
        6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
        1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
        2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   function automatic logic [63:0] perm64(input logic [63:0] v, input byte tab [64]);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-tab[i]];
      return r;
   endfunction

   function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_type k);
      logic [47:0] x;
      logic [5:0]  b;
      logic [31:0] s;
      logic [31:0] p;
      for (int i = 0; i < 48; i++) x[47-i] = r[32-E_TAB[i]];
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         b = x[47-6*i -: 6];
         s[31-4*i -: 4] = 4'(SBOX[i][{b[5], b[0], b[4:1]}]);
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32-P_TAB[i]];
      return p;
   endfunction

endpackage
`default_nettype wire

@@ rtl/des_block_cipher_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload
// req     | in  | tdata[63:0] block_in, tuser func
// rsp     | out | tdata[63:0] block_out
// csr     | in  | wdata[63:0] cipher_key
// One beat per cycle unless rsp stalls; req -> input reg -> result reg -> rsp beat.
// All sixteen rounds sit between the input and result registers.
// Key write updates the subkey registers the next cycle (reset key 0 via reset load).
// Synchronous reset clears valid flags; a stalled rsp holds the result reg, and
// once the input reg also holds a beat req_tready drops.
module des_block_cipher_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // block_in
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // block_out
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [63:0] csr_wdata
);
   import des_pkg::*;

   subkey_set_type subkeys;
   req_item_type   item_ff;
   logic           in_vld_ff;
   logic [63:0]    res_ff;
   logic           out_vld_ff;
   logic [63:0]    result;
   logic           out_free;
   logic           stage_go;

   assign csr_ready  = 1'b1;
   assign out_free   = !out_vld_ff || rsp_tready;
   assign stage_go   = !in_vld_ff || out_free;
   assign req_tready = stage_go;

   des_key_sched u_key (
      .clock   (clock),
      .load    (reset || csr_valid),
      .key     (reset ? 64'd0 : csr_wdata),
      .subkeys (subkeys)
   );

   des_rounds u_rounds (
      .func      (item_ff.func),
      .block_in  (item_ff.block),
      .subkeys   (subkeys),
      .block_out (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (stage_go) begin
            in_vld_ff <= req_tvalid;
            if (req_tvalid) item_ff <= '{func: req_tuser, block: req_tdata};
         end
         if (out_free) begin
            out_vld_ff <= in_vld_ff;
            if (in_vld_ff) res_ff <= result;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = res_ff;
endmodule
`default_nettype wire

@@ rtl/des_key_sched.sv @@
`timescale 1ns / 1ps
`default_nettype none
module des_key_sched (
   input  wire logic                    clock,
   input  wire logic                    load,
   input  wire logic [63:0]             key,
   output des_pkg::subkey_set_type      subkeys
);
   import des_pkg::*;

   subkey_set_type subkeys_ff;
   subkey_set_type subkeys_in;

   // subkeys held in registers, reloaded only on key write or reset
   always_comb begin
      logic [55:0] cd;
      logic [27:0] c;
      logic [27:0] d;
      for (int i = 0; i < 56; i++) cd[55-i] = key[64-PC1_TAB[i]];
      c = cd[55:28];
      d = cd[27:0];
      for (int r = 0; r < RoundCount; r++) begin
         if (SHIFT_TAB[r] == 1) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end else begin
            c = {c[25:0], c[27:26]};
            d = {d[25:0], d[27:26]};
         end
         cd = {c, d};
         for (int i = 0; i < 48; i++) subkeys_in[r][47-i] = cd[56-PC2_TAB[i]];
      end
   end

   always_ff @(posedge clock) begin
      if (load) subkeys_ff <= subkeys_in;
   end

   assign subkeys = subkeys_ff;
endmodule
`default_nettype wire

@@ rtl/des_rounds.sv @@
`timescale 1ns / 1ps
`default_nettype none
module des_rounds (
   input  wire logic                    func,
   input  wire logic [63:0]             block_in,
   input  des_pkg::subkey_set_type      subkeys,
   output logic [63:0]                  block_out
);
   import des_pkg::*;

   always_comb begin
      logic [63:0] v;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] nr;
      v = perm64(block_in, IP_TAB);
      l = v[63:32];
      r = v[31:0];
      for (int i = 0; i < RoundCount; i++) begin
         nr = l ^ feistel(r, (func == FUNC_DECRYPT) ? subkeys[RoundCount-1-i] : subkeys[i]);
         l = r;
         r = nr;
      end
      block_out = perm64({r, l}, FP_TAB);
   end
endmodule
`default_nettype wire
